// ===== rtl/rnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rnh_pkg
// Shared types and constants of the ray nearest-hit block: item and result
// payloads, datapath commands and status, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rnh_pkg;

    localparam int COORD_W   = 32;
    localparam int DIR_W     = 17;
    localparam int RAD_W     = 31;
    localparam int TAG_W     = 16;
    localparam int DIST_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int FRAC_BITS  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 2'd3;

    localparam logic signed [DIR_W-1:0] DIR_X_RESET = 17'sd32768;

    localparam logic KIND_CIRCLE = 1'b0;
    localparam logic KIND_EDGE   = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic                      new_ray;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [RAD_W-1:0]          radius;
        logic [TAG_W-1:0]          body_tag;
    } item_t;

    typedef struct packed {
        logic                      hit;
        logic                      nearest_valid;
        logic [TAG_W-1:0]          nearest_tag;
        logic signed [COORD_W-1:0] nearest_x;
        logic signed [COORD_W-1:0] nearest_y;
        logic [DIST_W-1:0]         nearest_dist_sq;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_PREP,
        OP_CDOT_X,
        OP_CDOT_Y,
        OP_FOOT_X,
        OP_FOOT_Y,
        OP_CCHK,
        OP_LSQ_X,
        OP_LSQ_Y,
        OP_RSQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CHIT_X,
        OP_CHIT_Y,
        OP_DEN_A,
        OP_DEN_B,
        OP_NUM_A,
        OP_NUM_B,
        OP_ECHK,
        OP_DIV_STEP,
        OP_EHIT_X,
        OP_EHIT_Y,
        OP_DMAG,
        OP_DSQ_X,
        OP_DSQ_Y,
        OP_RECORD
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic miss;
        logic kind;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rnh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rnh_ctrl
// Sequencer: steps the datapath through the circle or edge program, counts
// square root and divider iterations, and holds the record step while the
// output register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module rnh_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_ready,
    input  rnh_pkg::dp_status_t  status,
    output rnh_pkg::dp_cmd_t     cmd
);

    typedef enum logic [25:0] {
        S_IDLE      = 26'd1 << 0,
        S_PREP      = 26'd1 << 1,
        S_CDOT_X    = 26'd1 << 2,
        S_CDOT_Y    = 26'd1 << 3,
        S_FOOT_X    = 26'd1 << 4,
        S_FOOT_Y    = 26'd1 << 5,
        S_CCHK      = 26'd1 << 6,
        S_LSQ_X     = 26'd1 << 7,
        S_LSQ_Y     = 26'd1 << 8,
        S_RSQ       = 26'd1 << 9,
        S_SQRT_INIT = 26'd1 << 10,
        S_SQRT      = 26'd1 << 11,
        S_CHIT_X    = 26'd1 << 12,
        S_CHIT_Y    = 26'd1 << 13,
        S_DEN_A     = 26'd1 << 14,
        S_DEN_B     = 26'd1 << 15,
        S_NUM_A     = 26'd1 << 16,
        S_NUM_B     = 26'd1 << 17,
        S_ECHK      = 26'd1 << 18,
        S_DIV       = 26'd1 << 19,
        S_EHIT_X    = 26'd1 << 20,
        S_EHIT_Y    = 26'd1 << 21,
        S_DMAG      = 26'd1 << 22,
        S_DSQ_X     = 26'd1 << 23,
        S_DSQ_Y     = 26'd1 << 24,
        S_RECORD    = 26'd1 << 25
    } state_t;

    state_t                      state_reg, state_next;
    logic [rnh_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        item_ready = 1'b0;
        cmd.load   = 1'b0;
        cmd.op     = rnh_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op = rnh_pkg::OP_PREP;
                if (status.miss)
                    state_next = S_RECORD;
                else if (status.kind == rnh_pkg::KIND_EDGE)
                    state_next = S_DEN_A;
                else
                    state_next = S_CDOT_X;
            end
            S_CDOT_X:
            begin
                cmd.op     = rnh_pkg::OP_CDOT_X;
                state_next = S_CDOT_Y;
            end
            S_CDOT_Y:
            begin
                cmd.op     = rnh_pkg::OP_CDOT_Y;
                state_next = S_FOOT_X;
            end
            S_FOOT_X:
            begin
                cmd.op     = rnh_pkg::OP_FOOT_X;
                state_next = S_FOOT_Y;
            end
            S_FOOT_Y:
            begin
                cmd.op     = rnh_pkg::OP_FOOT_Y;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                cmd.op     = rnh_pkg::OP_CCHK;
                state_next = status.miss ? S_RECORD : S_LSQ_X;
            end
            S_LSQ_X:
            begin
                cmd.op     = rnh_pkg::OP_LSQ_X;
                state_next = S_LSQ_Y;
            end
            S_LSQ_Y:
            begin
                cmd.op     = rnh_pkg::OP_LSQ_Y;
                state_next = S_RSQ;
            end
            S_RSQ:
            begin
                cmd.op     = rnh_pkg::OP_RSQ;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.op   = rnh_pkg::OP_SQRT_INIT;
                cnt_next = rnh_pkg::CNT_W'(rnh_pkg::SQRT_STEPS - 1);
                state_next = status.miss ? S_RECORD : S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = rnh_pkg::OP_SQRT_STEP;
                if (cnt_reg == '0)
                    state_next = S_CHIT_X;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_CHIT_X:
            begin
                cmd.op     = rnh_pkg::OP_CHIT_X;
                state_next = S_CHIT_Y;
            end
            S_CHIT_Y:
            begin
                cmd.op     = rnh_pkg::OP_CHIT_Y;
                state_next = S_DMAG;
            end
            S_DEN_A:
            begin
                cmd.op     = rnh_pkg::OP_DEN_A;
                state_next = S_DEN_B;
            end
            S_DEN_B:
            begin
                cmd.op     = rnh_pkg::OP_DEN_B;
                state_next = S_NUM_A;
            end
            S_NUM_A:
            begin
                cmd.op     = rnh_pkg::OP_NUM_A;
                state_next = S_NUM_B;
            end
            S_NUM_B:
            begin
                cmd.op     = rnh_pkg::OP_NUM_B;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                cmd.op   = rnh_pkg::OP_ECHK;
                cnt_next = rnh_pkg::CNT_W'(rnh_pkg::FRAC_BITS - 1);
                state_next = status.miss ? S_RECORD : S_DIV;
            end
            S_DIV:
            begin
                cmd.op = rnh_pkg::OP_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = S_EHIT_X;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_EHIT_X:
            begin
                cmd.op     = rnh_pkg::OP_EHIT_X;
                state_next = S_EHIT_Y;
            end
            S_EHIT_Y:
            begin
                cmd.op     = rnh_pkg::OP_EHIT_Y;
                state_next = S_DMAG;
            end
            S_DMAG:
            begin
                cmd.op     = rnh_pkg::OP_DMAG;
                state_next = S_DSQ_X;
            end
            S_DSQ_X:
            begin
                cmd.op     = rnh_pkg::OP_DSQ_X;
                state_next = S_DSQ_Y;
            end
            S_DSQ_Y:
            begin
                cmd.op     = rnh_pkg::OP_DSQ_Y;
                state_next = S_RECORD;
            end
            S_RECORD:
            begin
                // wait for the output register to free up
                if (!status.out_busy)
                begin
                    cmd.op     = rnh_pkg::OP_RECORD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rnh_datapath.sv =====
// ----------------------------------------------------------------------------
// rnh_datapath
// Ray registers, item registers, one shared signed multiplier, the square root
// and divider iteration registers, the nearest-hit record and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rnh_datapath (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  rnh_pkg::dp_cmd_t                        cmd,
    output rnh_pkg::dp_status_t                     status,
    input  rnh_pkg::item_t                          item,
    input  wire                                     cfg_valid,
    input  wire  [rnh_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire  [rnh_pkg::CFG_DAT_W-1:0]           cfg_data,
    output logic                                    result_valid,
    input  wire                                     result_ready,
    output rnh_pkg::result_t                        result
);

    // ray
    logic signed [31:0] ox_reg, oy_reg;
    logic signed [16:0] dirx_reg, diry_reg;

    rnh_pkg::item_t     item_reg;

    logic signed [32:0] dx_reg, dy_reg, sx_reg, sy_reg;
    logic signed [32:0] dx_next, dy_next, sx_next, sy_next;
    logic signed [69:0] acc_reg, acc_next, acc2_reg, acc2_next;
    logic signed [38:0] px_reg, px_next, py_reg, py_next;
    logic [31:0]        lmx_reg, lmx_next, lmy_reg, lmy_next;
    logic [63:0]        rad_reg, rad_next, res_reg, res_next, bit_reg, bit_next;
    logic [51:0]        rem_reg, rem_next, ad_reg, ad_next;
    logic [29:0]        q_reg, q_next;
    logic signed [40:0] hx_reg, hx_next, hy_reg, hy_next;
    logic [31:0]        dmx_reg, dmx_next, dmy_reg, dmy_next;
    logic               dsatx_reg, dsatx_next, dsaty_reg, dsaty_next;
    logic [63:0]        dqx_reg, dqx_next, dqy_reg, dqy_next;
    logic               hit_reg, hit_next;

    logic [63:0]        best_dist_reg, best_dist_next;
    logic signed [31:0] best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [15:0]        best_tag_reg, best_tag_next;
    logic               best_found_reg, best_found_next;

    rnh_pkg::result_t   result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    // shared multiplier
    logic signed [35:0] ma;
    logic signed [32:0] mb;
    logic signed [68:0] prod, prod_s15, prod_s30;

    // combinational helpers
    logic signed [33:0] cxp, cxm, cyp, cym, ox34, oy34, rad34;
    logic               cull_circle, cull_edge, miss;
    logic signed [39:0] lx, ly;
    logic [39:0]        mag_lx, mag_ly;
    logic [64:0]        sq_sum;
    logic signed [69:0] den, num;
    logic [69:0]        den_mag, num_mag;
    logic [51:0]        rem_sh;
    logic signed [41:0] ddx, ddy;
    logic [41:0]        mag_dx, mag_dy;
    logic [64:0]        dsum;
    logic [63:0]        dist_sat;
    logic               upd;
    logic signed [31:0] hx_sat, hy_sat;

    assign prod     = ma * mb;
    assign prod_s15 = prod >>> 15;
    assign prod_s30 = prod >>> rnh_pkg::FRAC_BITS;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            rnh_pkg::OP_CDOT_X:
            begin
                ma = 36'(dx_reg);
                mb = 33'(dirx_reg);
            end
            rnh_pkg::OP_CDOT_Y:
            begin
                ma = 36'(dy_reg);
                mb = 33'(diry_reg);
            end
            rnh_pkg::OP_FOOT_X:
            begin
                ma = 36'(acc_reg >>> 15);
                mb = 33'(dirx_reg);
            end
            rnh_pkg::OP_FOOT_Y:
            begin
                ma = 36'(acc_reg >>> 15);
                mb = 33'(diry_reg);
            end
            rnh_pkg::OP_LSQ_X:
            begin
                ma = $signed({4'b0, lmx_reg});
                mb = $signed({1'b0, lmx_reg});
            end
            rnh_pkg::OP_LSQ_Y:
            begin
                ma = $signed({4'b0, lmy_reg});
                mb = $signed({1'b0, lmy_reg});
            end
            rnh_pkg::OP_RSQ:
            begin
                ma = $signed({5'b0, item_reg.radius});
                mb = $signed({2'b0, item_reg.radius});
            end
            rnh_pkg::OP_CHIT_X:
            begin
                ma = 36'(dirx_reg);
                mb = $signed({1'b0, res_reg[31:0]});
            end
            rnh_pkg::OP_CHIT_Y:
            begin
                ma = 36'(diry_reg);
                mb = $signed({1'b0, res_reg[31:0]});
            end
            rnh_pkg::OP_DEN_A:
            begin
                ma = 36'(sy_reg);
                mb = 33'(dirx_reg);
            end
            rnh_pkg::OP_DEN_B:
            begin
                ma = 36'(sx_reg);
                mb = 33'(diry_reg);
            end
            rnh_pkg::OP_NUM_A:
            begin
                ma = 36'(dx_reg);
                mb = 33'(diry_reg);
            end
            rnh_pkg::OP_NUM_B:
            begin
                ma = 36'(dy_reg);
                mb = 33'(dirx_reg);
            end
            rnh_pkg::OP_EHIT_X:
            begin
                ma = 36'(sx_reg);
                mb = $signed({3'b0, q_reg});
            end
            rnh_pkg::OP_EHIT_Y:
            begin
                ma = 36'(sy_reg);
                mb = $signed({3'b0, q_reg});
            end
            rnh_pkg::OP_DSQ_X:
            begin
                ma = $signed({4'b0, dmx_reg});
                mb = $signed({1'b0, dmx_reg});
            end
            rnh_pkg::OP_DSQ_Y:
            begin
                ma = $signed({4'b0, dmy_reg});
                mb = $signed({1'b0, dmy_reg});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // per-axis culls
    always_comb
    begin
        ox34  = 34'(ox_reg);
        oy34  = 34'(oy_reg);
        rad34 = $signed({3'b0, item_reg.radius});
        cxp   = 34'(item_reg.first_x) + rad34;
        cxm   = 34'(item_reg.first_x) - rad34;
        cyp   = 34'(item_reg.first_y) + rad34;
        cym   = 34'(item_reg.first_y) - rad34;
        cull_circle = (ox34 > cxp && dirx_reg > 17'sd0) ||
                      (ox34 < cxm && dirx_reg < 17'sd0) ||
                      (oy34 > cyp && diry_reg > 17'sd0) ||
                      (oy34 < cym && diry_reg < 17'sd0);
        cull_edge = (ox_reg > item_reg.first_x && dirx_reg > 17'sd0 &&
                     ox_reg > item_reg.second_x) ||
                    (ox_reg < item_reg.first_x && dirx_reg < 17'sd0 &&
                     ox_reg < item_reg.second_x) ||
                    (oy_reg < item_reg.first_y && diry_reg < 17'sd0 &&
                     oy_reg < item_reg.second_y) ||
                    (oy_reg > item_reg.first_y && diry_reg > 17'sd0 &&
                     oy_reg > item_reg.second_y);
    end

    always_comb
    begin
        lx     = 40'(px_reg) - 40'(item_reg.first_x);
        ly     = 40'(py_reg) - 40'(item_reg.first_y);
        mag_lx = lx[39] ? 40'(-lx) : 40'(lx);
        mag_ly = ly[39] ? 40'(-ly) : 40'(ly);

        sq_sum = {1'b0, res_reg} + {1'b0, bit_reg};

        // zero denominator stands in as 1.0 in Q.31
        den     = (acc_reg == 70'sd0) ? 70'sd2147483648 : acc_reg;
        num     = acc2_reg;
        den_mag = den[69] ? 70'(-den) : 70'(den);
        num_mag = num[69] ? 70'(-num) : 70'(num);
        rem_sh  = {rem_reg[50:0], 1'b0};

        ddx    = 42'(hx_reg) - 42'(ox_reg);
        ddy    = 42'(hy_reg) - 42'(oy_reg);
        mag_dx = ddx[41] ? 42'(-ddx) : 42'(ddx);
        mag_dy = ddy[41] ? 42'(-ddy) : 42'(ddy);

        dsum     = {1'b0, dqx_reg} + {1'b0, dqy_reg};
        dist_sat = dsum[64] ? '1 : dsum[63:0];
        upd      = hit_reg && (dist_sat < best_dist_reg);

        if (hx_reg > 41'sd2147483647)
            hx_sat = 32'sh7fffffff;
        else if (hx_reg < -41'sd2147483648)
            hx_sat = 32'sh80000000;
        else
            hx_sat = hx_reg[31:0];
        if (hy_reg > 41'sd2147483647)
            hy_sat = 32'sh7fffffff;
        else if (hy_reg < -41'sd2147483648)
            hy_sat = 32'sh80000000;
        else
            hy_sat = hy_reg[31:0];
    end

    always_comb
    begin
        case (cmd.op)
            rnh_pkg::OP_PREP:
                miss = (item_reg.kind == rnh_pkg::KIND_EDGE) ? cull_edge : cull_circle;
            rnh_pkg::OP_CCHK:
                miss = (mag_lx > 40'(item_reg.radius)) || (mag_ly > 40'(item_reg.radius));
            rnh_pkg::OP_SQRT_INIT:
                miss = acc_reg > acc2_reg;
            rnh_pkg::OP_ECHK:
                miss = (den > 70'sd0) ? !(num > 70'sd0 && num < den)
                                      : !(num < 70'sd0 && num > den);
            default:
                miss = 1'b0;
        endcase
    end

    assign status.miss     = miss;
    assign status.kind     = item_reg.kind;
    assign status.out_busy = result_valid_reg && !result_ready;

    always_comb
    begin
        dx_next = dx_reg;  dy_next = dy_reg;
        sx_next = sx_reg;  sy_next = sy_reg;
        acc_next = acc_reg;  acc2_next = acc2_reg;
        px_next = px_reg;  py_next = py_reg;
        lmx_next = lmx_reg;  lmy_next = lmy_reg;
        rad_next = rad_reg;  res_next = res_reg;  bit_next = bit_reg;
        rem_next = rem_reg;  ad_next = ad_reg;  q_next = q_reg;
        hx_next = hx_reg;  hy_next = hy_reg;
        dmx_next = dmx_reg;  dmy_next = dmy_reg;
        dsatx_next = dsatx_reg;  dsaty_next = dsaty_reg;
        dqx_next = dqx_reg;  dqy_next = dqy_reg;
        hit_next = hit_reg;
        best_dist_next  = best_dist_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        best_tag_next   = best_tag_reg;
        best_found_next = best_found_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        case (cmd.op)
            rnh_pkg::OP_PREP:
            begin
                dx_next  = 33'(item_reg.first_x) - 33'(ox_reg);
                dy_next  = 33'(item_reg.first_y) - 33'(oy_reg);
                sx_next  = 33'(item_reg.second_x) - 33'(item_reg.first_x);
                sy_next  = 33'(item_reg.second_y) - 33'(item_reg.first_y);
                hit_next = !miss;
                if (item_reg.new_ray)
                begin
                    best_dist_next  = '1;
                    best_x_next     = '0;
                    best_y_next     = '0;
                    best_tag_next   = '0;
                    best_found_next = 1'b0;
                end
            end
            rnh_pkg::OP_CDOT_X:
                acc_next = 70'(prod);
            rnh_pkg::OP_CDOT_Y:
                acc_next = acc_reg + 70'(prod);
            rnh_pkg::OP_FOOT_X:
                px_next = 39'(ox_reg) + 39'(prod_s15);
            rnh_pkg::OP_FOOT_Y:
                py_next = 39'(oy_reg) + 39'(prod_s15);
            rnh_pkg::OP_CCHK:
            begin
                lmx_next = mag_lx[31:0];
                lmy_next = mag_ly[31:0];
                if (miss)
                    hit_next = 1'b0;
            end
            rnh_pkg::OP_LSQ_X:
                acc_next = 70'(prod);
            rnh_pkg::OP_LSQ_Y:
                acc_next = acc_reg + 70'(prod);
            rnh_pkg::OP_RSQ:
                acc2_next = 70'(prod);
            rnh_pkg::OP_SQRT_INIT:
            begin
                rad_next = 64'(acc2_reg - acc_reg);
                res_next = '0;
                bit_next = 64'h4000_0000_0000_0000;
                if (miss)
                    hit_next = 1'b0;
            end
            rnh_pkg::OP_SQRT_STEP:
            begin
                if ({1'b0, rad_reg} >= sq_sum)
                begin
                    rad_next = rad_reg - sq_sum[63:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            rnh_pkg::OP_CHIT_X:
                hx_next = 41'(px_reg) - 41'(prod_s15);
            rnh_pkg::OP_CHIT_Y:
                hy_next = 41'(py_reg) - 41'(prod_s15);
            rnh_pkg::OP_DEN_A:
                acc_next = 70'(prod);
            rnh_pkg::OP_DEN_B:
                acc_next = acc_reg - 70'(prod);
            rnh_pkg::OP_NUM_A:
                acc2_next = 70'(prod);
            rnh_pkg::OP_NUM_B:
                acc2_next = acc2_reg - 70'(prod);
            rnh_pkg::OP_ECHK:
            begin
                rem_next = num_mag[51:0];
                ad_next  = den_mag[51:0];
                q_next   = '0;
                if (miss)
                    hit_next = 1'b0;
            end
            rnh_pkg::OP_DIV_STEP:
            begin
                if (rem_sh >= ad_reg)
                begin
                    rem_next = rem_sh - ad_reg;
                    q_next   = {q_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[28:0], 1'b0};
                end
            end
            rnh_pkg::OP_EHIT_X:
                hx_next = 41'(item_reg.first_x) + 41'(prod_s30);
            rnh_pkg::OP_EHIT_Y:
                hy_next = 41'(item_reg.first_y) + 41'(prod_s30);
            rnh_pkg::OP_DMAG:
            begin
                dmx_next   = mag_dx[31:0];
                dmy_next   = mag_dy[31:0];
                dsatx_next = mag_dx > 42'h0_FFFF_FFFF;
                dsaty_next = mag_dy > 42'h0_FFFF_FFFF;
            end
            rnh_pkg::OP_DSQ_X:
                dqx_next = dsatx_reg ? '1 : prod[63:0];
            rnh_pkg::OP_DSQ_Y:
                dqy_next = dsaty_reg ? '1 : prod[63:0];
            rnh_pkg::OP_RECORD:
            begin
                if (upd)
                begin
                    best_dist_next  = dist_sat;
                    best_x_next     = hx_sat;
                    best_y_next     = hy_sat;
                    best_tag_next   = item_reg.body_tag;
                    best_found_next = 1'b1;
                end
                result_next.hit             = hit_reg;
                result_next.nearest_valid   = upd ? 1'b1 : best_found_reg;
                result_next.nearest_tag     = upd ? item_reg.body_tag : best_tag_reg;
                result_next.nearest_x       = upd ? hx_sat : best_x_reg;
                result_next.nearest_y       = upd ? hy_sat : best_y_reg;
                result_next.nearest_dist_sq = upd ? dist_sat : best_dist_reg;
                result_valid_next           = 1'b1;
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
    end

    // control state and ray registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg           <= '0;
            oy_reg           <= '0;
            dirx_reg         <= rnh_pkg::DIR_X_RESET;
            diry_reg         <= '0;
            best_dist_reg    <= '1;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
            best_tag_reg     <= '0;
            best_found_reg   <= 1'b0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    rnh_pkg::CFG_ORIGIN_X: ox_reg   <= $signed(cfg_data);
                    rnh_pkg::CFG_ORIGIN_Y: oy_reg   <= $signed(cfg_data);
                    rnh_pkg::CFG_DIR_X:    dirx_reg <= $signed(cfg_data[16:0]);
                    rnh_pkg::CFG_DIR_Y:    diry_reg <= $signed(cfg_data[16:0]);
                    default:               ox_reg   <= ox_reg;
                endcase
            end
            best_dist_reg    <= best_dist_next;
            best_x_reg       <= best_x_next;
            best_y_reg       <= best_y_next;
            best_tag_reg     <= best_tag_next;
            best_found_reg   <= best_found_next;
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        dx_reg <= dx_next;  dy_reg <= dy_next;
        sx_reg <= sx_next;  sy_reg <= sy_next;
        acc_reg <= acc_next;  acc2_reg <= acc2_next;
        px_reg <= px_next;  py_reg <= py_next;
        lmx_reg <= lmx_next;  lmy_reg <= lmy_next;
        rad_reg <= rad_next;  res_reg <= res_next;  bit_reg <= bit_next;
        rem_reg <= rem_next;  ad_reg <= ad_next;  q_reg <= q_next;
        hx_reg <= hx_next;  hy_reg <= hy_next;
        dmx_reg <= dmx_next;  dmy_reg <= dmy_next;
        dsatx_reg <= dsatx_next;  dsaty_reg <= dsaty_next;
        dqx_reg <= dqx_next;  dqy_reg <= dqy_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/ray_nearest_hit_circle_segment.sv =====
// Flow: a circle that reaches the square root runs 32 root iterations, an edge
// runs 30 divider iterations, and an item culled at the first check goes straight
// to the record step; a full output register stalls the record step.
// One item at a time; item_ready rises in the same cycle that the result
// appears in the output register.
// Reset clears the ray to origin (0,0), direction (1.0,0), empties the record.
// ----------------------------------------------------------------------------
// ray_nearest_hit_circle_segment
// Nearest hit of a 2D ray against a stream of circles and polygon edges.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_nearest_hit_circle_segment (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               item_valid,
    output logic                              item_ready,
    input  rnh_pkg::item_t                    item,
    output logic                              result_valid,
    input  wire                               result_ready,
    output rnh_pkg::result_t                  result,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [rnh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [rnh_pkg::CFG_DAT_W-1:0]     cfg_data
);

    rnh_pkg::dp_cmd_t    cmd;
    rnh_pkg::dp_status_t status;

    // the user must write registers only while idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    rnh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rnh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/rnh_checker.sv =====
// ----------------------------------------------------------------------------
// rnh_assertions
// Port-level checks of the ray nearest-hit block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rnh_assertions (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              item_valid,
    input wire                              item_ready,
    input rnh_pkg::item_t                   item,
    input wire                              result_valid,
    input wire                              result_ready,
    input rnh_pkg::result_t                 result,
    input wire                              cfg_valid,
    input wire                              cfg_ready
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // waiting item holds
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item changed while waiting");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while busy");

    // empty record reads as cleared
    a_empty_record: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.nearest_valid |->
            result.nearest_dist_sq == '1 && result.nearest_tag == '0 &&
            result.nearest_x == '0 && result.nearest_y == '0)
        else $error("empty record not cleared");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind ray_nearest_hit_circle_segment rnh_assertions u_rnh_assertions (.*);

`default_nettype wire
